### sv/pmsr_pkg.sv
// Shared types, constants and coefficient ROM for the pointer motion block.
// Used by pmsr_scroll_axis, pmsr_rotate and pointer_motion_scroll_rotate.
`timescale 1ns / 1ps
`default_nettype none

package pmsr_pkg;

    // Angle table size and coefficient precision.
    localparam int ANGLE_COUNT    = 11;
    localparam int COEF_FRAC_BITS = 14;
    localparam int ROM_FRAC_BITS  = 30;
    localparam int ROM_ENTRIES    = 11;
    localparam int TAB_COUNT      = (ANGLE_COUNT < ROM_ENTRIES) ? ANGLE_COUNT : ROM_ENTRIES;
    localparam int OUT_LIMIT      = 127;

    // Field widths.
    localparam int DATA_W     = 8;
    localparam int ACC_W      = 10;
    localparam int IDX_W      = 4;
    localparam int THR_W      = 7;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic             RST_DRAGSCROLL = 1'b0;
    localparam logic [IDX_W-1:0] RST_ROT_INDEX  = 4'd5;
    localparam logic [THR_W-1:0] RST_THRESHOLD  = 7'd6;
    localparam logic             RST_REV_X      = 1'b0;
    localparam logic             RST_REV_Y      = 1'b0;

    // Register indexes (byte address divided by four).
    typedef enum logic [2:0] {
        REG_DRAGSCROLL = 3'd0,
        REG_ROT_INDEX  = 3'd1,
        REG_THRESHOLD  = 3'd2,
        REG_REV_X      = 3'd3,
        REG_REV_Y      = 3'd4
    } t_reg_idx;

    // Input and result payloads.
    typedef struct packed {
        logic signed [DATA_W-1:0] dx;
        logic signed [DATA_W-1:0] dy;
        logic signed [DATA_W-1:0] wheel_h_in;
        logic signed [DATA_W-1:0] wheel_v_in;
    } t_motion_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] wheel_h_out;
        logic signed [DATA_W-1:0] wheel_v_out;
    } t_motion_out;

    // Per-axis scroll settings.
    typedef struct packed {
        logic             reverse;
        logic [THR_W-1:0] threshold;
    } t_scroll_cfg;

    // Cos and sin of -75 to 75 degrees in 15 degree steps, 30 fraction bits.
    localparam logic signed [31:0] COS_ROM [ROM_ENTRIES] = '{
        32'sd277904834, 32'sd536870912, 32'sd759250125, 32'sd929887697,
        32'sd1037154959, 32'sd1073741824, 32'sd1037154959, 32'sd929887697,
        32'sd759250125, 32'sd536870912, 32'sd277904834
    };
    localparam logic signed [31:0] SIN_ROM [ROM_ENTRIES] = '{
        -32'sd1037154959, -32'sd929887697, -32'sd759250125, -32'sd536870912,
        -32'sd277904834, 32'sd0, 32'sd277904834, 32'sd536870912,
        32'sd759250125, 32'sd929887697, 32'sd1037154959
    };

    // Rounds a ROM entry half away from zero to the given fraction bits.
    // Called on constants only, so it folds away at elaboration.
    function automatic logic signed [31:0] rom_round(input logic signed [31:0] v,
                                                     input int frac);
        logic [31:0] mag;
        logic [31:0] rnd;
        int          sh;
        sh  = ROM_FRAC_BITS - frac;
        mag = v[31] ? 32'(-v) : 32'(v);
        rnd = (mag + (32'd1 << (sh - 1))) >> sh;
        return v[31] ? -$signed(rnd) : $signed(rnd);
    endfunction

endpackage

`default_nettype wire

### sv/pmsr_scroll_axis.sv
// One drag-scroll axis: the kept accumulator and its threshold step.
// Depends on pmsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmsr_scroll_axis
    import pmsr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_update,
    input  t_scroll_cfg              i_cfg,
    input  logic signed [DATA_W-1:0] i_delta,
    input  logic signed [DATA_W-1:0] i_wheel,
    output logic signed [DATA_W-1:0] o_wheel
);

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_sum;
    logic        [ACC_W-1:0] w_mag;
    logic                    w_step;

    // Add or subtract the delta, wrapping within the accumulator width.
    assign w_sum  = i_cfg.reverse ? (r_acc - ACC_W'(i_delta)) : (r_acc + ACC_W'(i_delta));
    assign w_mag  = w_sum[ACC_W-1] ? ACC_W'(-w_sum) : ACC_W'(w_sum);
    assign w_step = w_mag > ACC_W'(i_cfg.threshold);

    // A step clears the accumulator and replaces the wheel with the sign.
    assign n_acc   = w_step ? '0 : w_sum;
    assign o_wheel = w_step ? (w_sum[ACC_W-1] ? -8'sd1 : 8'sd1) : i_wheel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_update) begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

### sv/pmsr_rotate.sv
// Motion rotation: coefficient lookup, four products, rounding and clamping.
// Depends on pmsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmsr_rotate
    import pmsr_pkg::*;
#(
    parameter int COEF_FRAC = COEF_FRAC_BITS
) (
    input  logic signed [DATA_W-1:0] i_dx,
    input  logic signed [DATA_W-1:0] i_dy,
    input  logic        [IDX_W-1:0]  i_index,
    output logic signed [DATA_W-1:0] o_rx,
    output logic signed [DATA_W-1:0] o_ry
);

    // Coefficients reach 1.0, so two integer bits; sums gain headroom.
    localparam int CW = COEF_FRAC + 2;
    localparam int MW = CW + DATA_W;
    localparam int PW = MW + 1;

    logic signed [CW-1:0] w_cos_tab [ROM_ENTRIES];
    logic signed [CW-1:0] w_sin_tab [ROM_ENTRIES];
    logic        [IDX_W-1:0] w_idx;
    logic signed [CW-1:0] w_cos;
    logic signed [CW-1:0] w_sin;
    logic signed [MW-1:0] w_xc;
    logic signed [MW-1:0] w_xs;
    logic signed [MW-1:0] w_yc;
    logic signed [MW-1:0] w_ys;
    logic signed [PW-1:0] w_sum_x;
    logic signed [PW-1:0] w_sum_y;

    // Constant coefficient table rounded to the working precision.
    for (genvar g = 0; g < ROM_ENTRIES; g++) begin : g_tab
        assign w_cos_tab[g] = CW'(rom_round(COS_ROM[g], COEF_FRAC));
        assign w_sin_tab[g] = CW'(rom_round(SIN_ROM[g], COEF_FRAC));
    end

    // Indexes past the table end use the last entry.
    assign w_idx = (i_index < IDX_W'(TAB_COUNT)) ? i_index : IDX_W'(TAB_COUNT - 1);
    assign w_cos = w_cos_tab[w_idx];
    assign w_sin = w_sin_tab[w_idx];

    // Rotation by the negated angle.
    assign w_xc    = i_dx * w_cos;
    assign w_xs    = i_dx * w_sin;
    assign w_yc    = i_dy * w_cos;
    assign w_ys    = i_dy * w_sin;
    assign w_sum_x = PW'(w_xc) + PW'(w_ys);
    assign w_sum_y = PW'(w_yc) - PW'(w_xs);

    // Round half away from zero to an integer and saturate the magnitude.
    function automatic logic signed [DATA_W-1:0] round_clamp(input logic signed [PW-1:0] s);
        logic [PW-1:0]     mag;
        logic [PW-1:0]     rnd;
        logic [DATA_W-1:0] lim;
        mag = s[PW-1] ? PW'(-s) : PW'(s);
        rnd = (mag + (PW'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
        lim = (rnd > PW'(OUT_LIMIT)) ? DATA_W'(OUT_LIMIT) : rnd[DATA_W-1:0];
        return s[PW-1] ? -$signed(lim) : $signed(lim);
    endfunction

    assign o_rx = round_clamp(w_sum_x);
    assign o_ry = round_clamp(w_sum_y);

endmodule

`default_nettype wire

### sv/pointer_motion_scroll_rotate.sv
// Pointer motion post-processing: drag-scroll accumulation or motion rotation.
// Input transfers load the input register; each item then moves into the result register,
// which drives o_out_valid. Throughput: one item per cycle while i_out_ready stays high,
// with a combinational rotate and scroll path between the two registers. Synchronous
// active-low reset clears the pipeline valids and both accumulators and loads register
// defaults. Depends on pmsr_pkg, pmsr_rotate, pmsr_scroll_axis.
`timescale 1ns / 1ps
`default_nettype none

module pointer_motion_scroll_rotate
    import pmsr_pkg::*;
#(
    parameter int COEF_FRAC = COEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Motion reports in
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_motion_in            i_in_data,
    // Processed reports out
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_motion_out           o_out_data
);

    logic             r_dragscroll;
    logic [IDX_W-1:0] r_rot_index;
    logic [THR_W-1:0] r_threshold;
    logic             r_rev_x;
    logic             r_rev_y;

    logic             r_s1_valid;
    t_motion_in       r_s1_data;
    logic             r_out_valid;
    t_motion_out      r_out_data;
    t_motion_out      n_out_data;

    logic             w_cfg_write;
    logic [2:0]       w_reg_idx;
    logic             w_out_free;
    logic             w_s1_adv;
    logic             w_in_xfer;
    t_scroll_cfg      w_cfg_x;
    t_scroll_cfg      w_cfg_y;
    logic signed [DATA_W-1:0] w_rx;
    logic signed [DATA_W-1:0] w_ry;
    logic signed [DATA_W-1:0] w_wheel_h;
    logic signed [DATA_W-1:0] w_wheel_v;

    // Register file access.
    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[APB_ADDR_W-1:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dragscroll <= RST_DRAGSCROLL;
            r_rot_index  <= RST_ROT_INDEX;
            r_threshold  <= RST_THRESHOLD;
            r_rev_x      <= RST_REV_X;
            r_rev_y      <= RST_REV_Y;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_DRAGSCROLL: r_dragscroll <= pwdata[0];
                REG_ROT_INDEX:  r_rot_index  <= pwdata[IDX_W-1:0];
                REG_THRESHOLD:  r_threshold  <= pwdata[THR_W-1:0];
                REG_REV_X:      r_rev_x      <= pwdata[0];
                REG_REV_Y:      r_rev_y      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back of the registers.
    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_DRAGSCROLL: prdata = APB_DATA_W'(r_dragscroll);
            REG_ROT_INDEX:  prdata = APB_DATA_W'(r_rot_index);
            REG_THRESHOLD:  prdata = APB_DATA_W'(r_threshold);
            REG_REV_X:      prdata = APB_DATA_W'(r_rev_x);
            REG_REV_Y:      prdata = APB_DATA_W'(r_rev_y);
            default:        prdata = '0;
        endcase
    end

    // Pipeline flow: input register advances whenever the result register frees.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= w_in_xfer || (r_s1_valid && !w_s1_adv);
            r_out_valid <= w_s1_adv || (r_out_valid && !i_out_ready);
        end
        if (w_in_xfer) begin
            r_s1_data <= i_in_data;
        end
        if (w_s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // Drag-scroll axes update only on a transfer in drag-scroll mode.
    assign w_cfg_x = '{reverse: r_rev_x, threshold: r_threshold};
    assign w_cfg_y = '{reverse: r_rev_y, threshold: r_threshold};

    pmsr_scroll_axis u_scroll_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_s1_adv && r_dragscroll),
        .i_cfg    (w_cfg_x),
        .i_delta  (r_s1_data.dx),
        .i_wheel  (r_s1_data.wheel_h_in),
        .o_wheel  (w_wheel_h)
    );

    pmsr_scroll_axis u_scroll_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_s1_adv && r_dragscroll),
        .i_cfg    (w_cfg_y),
        .i_delta  (r_s1_data.dy),
        .i_wheel  (r_s1_data.wheel_v_in),
        .o_wheel  (w_wheel_v)
    );

    pmsr_rotate #(
        .COEF_FRAC (COEF_FRAC)
    ) u_rotate (
        .i_dx    (r_s1_data.dx),
        .i_dy    (r_s1_data.dy),
        .i_index (r_rot_index),
        .o_rx    (w_rx),
        .o_ry    (w_ry)
    );

    // Result selection by mode.
    always_comb begin
        if (r_dragscroll) begin
            n_out_data.out_x       = '0;
            n_out_data.out_y       = '0;
            n_out_data.wheel_h_out = w_wheel_h;
            n_out_data.wheel_v_out = w_wheel_v;
        end else begin
            n_out_data.out_x       = w_rx;
            n_out_data.out_y       = w_ry;
            n_out_data.wheel_h_out = r_s1_data.wheel_h_in;
            n_out_data.wheel_v_out = r_s1_data.wheel_v_in;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

### test/tb_pointer_motion_scroll_rotate.sv
// Self-checking testbench for pointer_motion_scroll_rotate: a directed table, then random phases.
// Depends on pmsr_pkg and on the block's RTL. Each result is checked against a table value or a
// predictor that keeps its own copy of the settings and of both scroll accumulators.
`timescale 1ns / 1ps

module tb_pointer_motion_scroll_rotate;
    import pmsr_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_REPORTS    = 175;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_AFTER  = 700;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MISMATCH_SHOWN   = 10;
    localparam int ANGLE_ROWS       = 11;
    localparam int Q30_FRAC         = 30;
    localparam int Q14_FRAC         = 14;
    localparam int MOTION_MAX       = 127;

    // Cos and sin of -75 to 75 degrees in 15 degree steps, 30 fraction bits.
    localparam int COS_Q30 [ANGLE_ROWS] = '{
        277904834, 536870912, 759250125, 929887697, 1037154959, 1073741824,
        1037154959, 929887697, 759250125, 536870912, 277904834
    };
    localparam int SIN_Q30 [ANGLE_ROWS] = '{
        -1037154959, -929887697, -759250125, -536870912, -277904834, 0,
        277904834, 536870912, 759250125, 929887697, 1037154959
    };

    // One row of the directed table: either a register write or a motion report.
    typedef struct packed {
        logic        is_cfg;
        t_reg_idx    reg_sel;
        logic [31:0] wval;
        t_motion_in  item;
        logic        has_want;
        t_motion_out want;
    } t_directed_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_motion_in            i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_motion_out           o_out_data;

    // Settings and accumulators as the predictor sees them.
    logic                     mode_scroll;
    logic [IDX_W-1:0]         angle_sel;
    logic [THR_W-1:0]         scroll_limit;
    logic                     invert_x;
    logic                     invert_y;
    logic signed [ACC_W-1:0]  scroll_sum_x;
    logic signed [ACC_W-1:0]  scroll_sum_y;

    t_motion_out   pending_reports [$];
    t_directed_row directed_rows [$];
    t_motion_out   oldest_report;
    int            mismatches    = 0;
    int            reports_seen  = 0;
    int            stall_left    = 0;
    int            steady_left   = 0;
    int            ready_roll;
    bit            long_hold_done = 1'b0;
    int            cycle_count;

    pointer_motion_scroll_rotate uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Rounds a Q30 table entry half away from zero to a Q14 coefficient.
    function automatic longint q14_coef(input longint q30);
        longint mag;
        longint r;
        mag = (q30 < 0) ? -q30 : q30;
        r   = (mag + (longint'(1) << (Q30_FRAC - Q14_FRAC - 1))) >>> (Q30_FRAC - Q14_FRAC);
        return (q30 < 0) ? -r : r;
    endfunction

    // Rounds a Q14 sum half away from zero to an integer and limits it to +/-127.
    function automatic logic signed [DATA_W-1:0] round_and_limit(input longint sum);
        longint mag;
        longint r;
        mag = (sum < 0) ? -sum : sum;
        r   = (mag + (longint'(1) << (Q14_FRAC - 1))) >>> Q14_FRAC;
        if (r > MOTION_MAX) begin
            r = MOTION_MAX;
        end
        return (sum < 0) ? 8'(-r) : 8'(r);
    endfunction

    // Adds one motion delta into an accumulator; a crossing emits a step and clears it.
    function automatic logic signed [DATA_W-1:0] scroll_axis_step(
        input  logic signed [ACC_W-1:0]  acc,
        input  int                       delta,
        input  logic                     invert,
        input  logic signed [DATA_W-1:0] wheel,
        output logic signed [ACC_W-1:0]  acc_next
    );
        int                      sum;
        int                      mag;
        logic signed [ACC_W-1:0] wrapped;
        sum     = invert ? int'(acc) - delta : int'(acc) + delta;
        wrapped = sum[ACC_W-1:0];
        mag     = (wrapped < 0) ? -int'(wrapped) : int'(wrapped);
        if (mag > int'(scroll_limit)) begin
            acc_next = '0;
            return (wrapped > 0) ? 8'sd1 : -8'sd1;
        end
        acc_next = wrapped;
        return wheel;
    endfunction

    // Works out the processed report for one accepted motion report.
    function automatic t_motion_out process_report(input t_motion_in m);
        t_motion_out             r;
        int                      x;
        int                      y;
        int                      sel;
        longint                  c;
        longint                  s;
        logic signed [ACC_W-1:0] next_x;
        logic signed [ACC_W-1:0] next_y;
        x = int'(m.dx);
        y = int'(m.dy);
        if (mode_scroll) begin
            r.out_x       = '0;
            r.out_y       = '0;
            r.wheel_h_out = scroll_axis_step(scroll_sum_x, x, invert_x, m.wheel_h_in, next_x);
            r.wheel_v_out = scroll_axis_step(scroll_sum_y, y, invert_y, m.wheel_v_in, next_y);
            scroll_sum_x  = next_x;
            scroll_sum_y  = next_y;
        end else begin
            // Indexes past the end of the angle table use the last entry.
            sel           = (angle_sel < ANGLE_ROWS) ? int'(angle_sel) : ANGLE_ROWS - 1;
            c             = q14_coef(COS_Q30[sel]);
            s             = q14_coef(SIN_Q30[sel]);
            r.out_x       = round_and_limit(longint'(x) * c + longint'(y) * s);
            r.out_y       = round_and_limit(longint'(y) * c - longint'(x) * s);
            r.wheel_h_out = m.wheel_h_in;
            r.wheel_v_out = m.wheel_v_in;
        end
        return r;
    endfunction

    function automatic void add_report(input int dx, input int dy, input int wh, input int wv,
                                       input bit known, input int ex, input int ey,
                                       input int eh, input int ev);
        t_directed_row r;
        r                    = '0;
        r.item.dx            = 8'(dx);
        r.item.dy            = 8'(dy);
        r.item.wheel_h_in    = 8'(wh);
        r.item.wheel_v_in    = 8'(wv);
        r.has_want           = known;
        r.want.out_x         = 8'(ex);
        r.want.out_y         = 8'(ey);
        r.want.wheel_h_out   = 8'(eh);
        r.want.wheel_v_out   = 8'(ev);
        directed_rows.push_back(r);
    endfunction

    function automatic void add_setting(input t_reg_idx sel, input logic [31:0] value);
        t_directed_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_sel = sel;
        r.wval    = value;
        directed_rows.push_back(r);
    endfunction

    // Field values lean toward the extremes now and then.
    function automatic logic [DATA_W-1:0] random_field();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Sometimes sets the bits above a register's width; the block must ignore them.
    function automatic logic [31:0] pad_high(input logic [31:0] v, input int width);
        if ($urandom_range(0, 3) == 0) begin
            return v | ($urandom << width);
        end
        return v;
    endfunction

    // Sender gaps: mostly none or short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(13, 40);
    endfunction

    // One register write: setup cycle, then access cycle; pready is always high.
    task automatic write_register(input t_reg_idx sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_DRAGSCROLL: mode_scroll  = value[0];
            REG_ROT_INDEX:  angle_sel    = value[IDX_W-1:0];
            REG_THRESHOLD:  scroll_limit = value[THR_W-1:0];
            REG_REV_X:      invert_x     = value[0];
            REG_REV_Y:      invert_y     = value[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one report and waits for its transfer, then records the expected result.
    task automatic send_report(input t_motion_in m, input logic known, input t_motion_out want);
        t_motion_out predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= m;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predicted = process_report(m);
        pending_reports.push_back(known ? want : predicted);
    endtask

    task automatic hold_input(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drains the block before settings change or the run ends.
    task automatic wait_idle();
        if (i_in_valid) begin
            hold_input(1);
        end
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatches < MISMATCH_SHOWN) begin
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
        mismatches++;
    endtask

    // Result side: check each transfer against the oldest expectation, then drive ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                note_mismatch("report with none expected", '0, 32'(o_out_data));
            end else begin
                oldest_report = pending_reports.pop_front();
                if (oldest_report.out_x !== o_out_data.out_x) begin
                    note_mismatch("out_x", 32'(oldest_report.out_x), 32'(o_out_data.out_x));
                end
                if (oldest_report.out_y !== o_out_data.out_y) begin
                    note_mismatch("out_y", 32'(oldest_report.out_y), 32'(o_out_data.out_y));
                end
                if (oldest_report.wheel_h_out !== o_out_data.wheel_h_out) begin
                    note_mismatch("wheel_h_out", 32'(oldest_report.wheel_h_out),
                                  32'(o_out_data.wheel_h_out));
                end
                if (oldest_report.wheel_v_out !== o_out_data.wheel_v_out) begin
                    note_mismatch("wheel_v_out", 32'(oldest_report.wheel_v_out),
                                  32'(o_out_data.wheel_v_out));
                end
            end
        end

        // Once in the run the receiver holds off long enough to back up the input.
        if (!long_hold_done && reports_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (steady_left > 0) begin
            steady_left--;
            i_out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                i_out_ready <= 1'b1;
            end else if (ready_roll < 88) begin
                stall_left  = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else if (ready_roll < 95) begin
                stall_left  = $urandom_range(5, 40);
                i_out_ready <= 1'b0;
            end else begin
                steady_left = $urandom_range(20, 80);
                i_out_ready <= 1'b1;
            end
        end
    end

    // Ends a run that hangs.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pointer_motion_scroll_rotate regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_directed_row row;
        t_motion_in    m;
        logic [31:0]   v;

        mode_scroll  = 1'b0;
        angle_sel    = 4'd5;
        scroll_limit = 7'd6;
        invert_x     = 1'b0;
        invert_y     = 1'b0;
        scroll_sum_x = '0;
        scroll_sum_y = '0;

        // Reset settings give the identity rotation; only -128 is clamped.
        add_report(0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_report(127, -128, -128, 127, 1, 127, -127, -128, 127);
        add_report(-128, 127, 127, -128, 1, -127, 127, 127, -128);
        add_report(1, -1, 5, -5, 1, 1, -1, 5, -5);
        // Both ends of the angle table, then an index past its end.
        add_setting(REG_ROT_INDEX, 0);
        add_report(127, 127, 0, 0, 0, 0, 0, 0, 0);
        add_report(-128, -128, 1, -1, 0, 0, 0, 0, 0);
        add_setting(REG_ROT_INDEX, 10);
        add_report(127, -128, -128, 127, 0, 0, 0, 0, 0);
        add_report(100, 37, 2, -2, 0, 0, 0, 0, 0);
        add_setting(REG_ROT_INDEX, 32'hFFFF_FFFF);
        add_report(127, 0, 9, -9, 0, 0, 0, 0, 0);
        add_report(0, 127, -9, 9, 0, 0, 0, 0, 0);
        add_setting(REG_ROT_INDEX, 3);
        add_report(64, -64, 0, 0, 0, 0, 0, 0, 0);
        // Drag-scroll with a zero threshold: any nonzero sum steps.
        add_setting(REG_DRAGSCROLL, 1);
        add_setting(REG_THRESHOLD, 32'hFFFF_FF80);
        add_report(1, -1, 33, -33, 1, 0, 0, 1, -1);
        add_report(0, 0, 33, -33, 1, 0, 0, 33, -33);
        // Highest threshold: a sum of exactly 127 does not step.
        add_setting(REG_THRESHOLD, 127);
        add_report(127, 127, 10, 20, 1, 0, 0, 10, 20);
        add_report(1, -128, 10, 20, 1, 0, 0, 1, 20);
        add_report(-128, -128, 10, 20, 1, 0, 0, -1, -1);
        // Reversed axes, pushed to the largest sums that can build up.
        add_setting(REG_REV_X, 1);
        add_setting(REG_REV_Y, 1);
        add_report(5, -5, 3, 4, 1, 0, 0, 3, 4);
        add_report(-128, 127, 3, 4, 0, 0, 0, 0, 0);
        add_report(-128, 127, 3, 4, 0, 0, 0, 0, 0);
        add_setting(REG_REV_X, 32'hFFFF_FFFE);
        add_setting(REG_REV_Y, 32'h0000_0002);
        add_setting(REG_DRAGSCROLL, 32'hFFFF_FFFE);
        add_setting(REG_THRESHOLD, 6);
        add_setting(REG_ROT_INDEX, 8);
        add_report(-7, 7, -128, 127, 0, 0, 0, 0, 0);
        add_report(127, 127, 0, 0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < directed_rows.size(); k++) begin
            row = directed_rows[k];
            if (row.is_cfg) begin
                wait_idle();
                write_register(row.reg_sel, row.wval);
            end else begin
                send_report(row.item, row.has_want, row.want);
                hold_input(pick_gap());
            end
        end

        // Random phases alternate between rotation and drag-scroll with fresh settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            write_register(REG_DRAGSCROLL, pad_high(32'(phase % 2), 1));
            v = (phase == 0) ? 32'd0 : (phase == 2) ? 32'd10 : $urandom_range(0, 15);
            write_register(REG_ROT_INDEX, pad_high(v, IDX_W));
            v = (phase == 1) ? 32'd0 : (phase == 3) ? 32'd127 : $urandom_range(0, 30);
            write_register(REG_THRESHOLD, pad_high(v, THR_W));
            write_register(REG_REV_X, pad_high($urandom_range(0, 1), 1));
            write_register(REG_REV_Y, pad_high($urandom_range(0, 1), 1));
            for (int n = 0; n < PHASE_REPORTS; n++) begin
                m.dx         = random_field();
                m.dy         = random_field();
                m.wheel_h_in = random_field();
                m.wheel_v_in = random_field();
                send_report(m, 1'b0, '0);
                hold_input(pick_gap());
            end
        end

        wait_idle();
        mismatches += pending_reports.size();
        if (mismatches == 0) begin
            $display("pointer_motion_scroll_rotate regression: pass");
        end else begin
            $display("pointer_motion_scroll_rotate regression: fail");
        end
        $finish;
    end

endmodule
